[rtl/global_to_local_row_map_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the global-to-local row map
// Short forms for clocked concurrent assertions on clock and reset.
// ----------------------------------------------------------------------------
`ifndef GLOBAL_TO_LOCAL_ROW_MAP_ASSERT_SVH
`define GLOBAL_TO_LOCAL_ROW_MAP_ASSERT_SVH

// Checked only outside reset.
`define G2L_ASSERT_SYNC(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define G2L_ASSERT_ANY(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/g2l_pkg.sv]
// ----------------------------------------------------------------------------
// g2l_pkg
// Widths, codes and shared types of the global-to-local row map.
// ----------------------------------------------------------------------------
package g2l_pkg;

   localparam int GHOST_DEPTH = 1024;
   localparam int IDX_W       = (GHOST_DEPTH > 1) ? $clog2(GHOST_DEPTH) : 1;
   localparam int CNT_W       = $clog2(GHOST_DEPTH + 1);

   localparam int ROW_W       = 32;
   localparam int SLOT_W      = 10;
   localparam int BEGIN_W     = 32;
   localparam int OCOUNT_W    = 31;
   localparam int GCOUNT_W    = 11;
   localparam int INDEX_W     = 32;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;
   localparam int REG_IDX_W   = 2;

   localparam logic [REG_IDX_W-1:0] REG_OWNED_BEGIN = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_OWNED_COUNT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_GHOST_COUNT = 2'd2;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_LOAD   = 1'b1;

   typedef struct packed {
      logic [BEGIN_W-1:0]  owned_begin;
      logic [OCOUNT_W-1:0] owned_count;
      logic [GCOUNT_W-1:0] ghost_count;
   } cfg_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [ROW_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

endpackage

[rtl/g2l_if.sv]
// ----------------------------------------------------------------------------
// g2l channel interfaces
// Valid/ready channels for request items and lookup results.
// ----------------------------------------------------------------------------
interface g2l_req_if;
   import g2l_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [ROW_W-1:0]  row;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, output mode, output row, output slot, input ready);
   modport sink   (input valid, input mode, input row, input slot, output ready);
endinterface

interface g2l_rsp_if;
   import g2l_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] local_index;
   logic               found;
   logic               is_ghost;

   modport source (output valid, output local_index, output found, output is_ghost,
                   input ready);
   modport sink   (input valid, input local_index, input found, input is_ghost,
                   output ready);
endinterface

[rtl/global_to_local_row_map.sv]
// ----------------------------------------------------------------------------
// global_to_local_row_map
// Maps a global row to a local slot: owned range first, then a lower-bound
// binary search over the sorted ghost table.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  req_ch   | in        | mode 0: lookup of row; mode 1: store row at slot
//  rsp_ch   | out       | local_index, found, is_ghost for each lookup
//  csr      | in (APB)  | owned_begin, owned_count, ghost_count at 0x0/0x4/0x8
//
// A load writes the table on acceptance and leaves the block ready. An owned
// lookup passes the check and result states to the output register; a ghost
// lookup adds one search step per probe (at most eleven with 1024 entries,
// none when empty) and a final check, each with one read through the single read port.
// The output register lets the next item enter while a result waits; a
// lookup that finishes before that result is taken holds until it is.
// Reset clears only the configuration, the control state and the result valid; the table is not cleared.
// ----------------------------------------------------------------------------
`include "global_to_local_row_map_assert.svh"

module global_to_local_row_map (
   input  logic                            clock,
   input  logic                            reset,
   g2l_req_if.sink                         req_ch,
   g2l_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [g2l_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [g2l_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [g2l_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import g2l_pkg::*;

   cfg_type          cfg;
   ram_req_type      ram_req;
   logic [ROW_W-1:0] rd_data;

   g2l_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   g2l_ghost_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   g2l_search_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   `G2L_ASSERT_SYNC(a_miss_is_zero,
      rsp_ch.valid && !rsp_ch.found |-> rsp_ch.local_index == '0 && !rsp_ch.is_ghost,
      "miss result carries a nonzero index or ghost flag")
   `G2L_ASSERT_SYNC(a_ghost_is_found,
      rsp_ch.valid && rsp_ch.is_ghost |-> rsp_ch.found,
      "ghost hit reported without found")
   `G2L_ASSERT_SYNC(a_lookup_busy,
      req_ch.valid && req_ch.ready && req_ch.mode == MODE_LOOKUP |=> !req_ch.ready,
      "lookup accepted but request side still ready")
   `G2L_ASSERT_ANY(a_reset_clears,
      reset |=> !rsp_ch.valid && req_ch.ready,
      "reset left a result pending or the block busy")

endmodule

[rtl/g2l_ghost_ram.sv]
// ----------------------------------------------------------------------------
// g2l_ghost_ram
// Ghost row table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module g2l_ghost_ram (
   input  logic                         clock,
   input  g2l_pkg::ram_req_type         ram_req,
   output logic [g2l_pkg::ROW_W-1:0]    rd_data
);
   import g2l_pkg::*;

   logic [ROW_W-1:0] mem [GHOST_DEPTH];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/g2l_csr.sv]
// ----------------------------------------------------------------------------
// g2l_csr
// APB register file holding the owned range and the ghost entry count.
// ----------------------------------------------------------------------------
module g2l_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [g2l_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [g2l_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [g2l_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output g2l_pkg::cfg_type                cfg
);
   import g2l_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic                  wr_stb;
   logic [REG_IDX_W-1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_stb  = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (reg_idx)
            REG_OWNED_BEGIN: cfg_in.owned_begin = pwdata[BEGIN_W-1:0];
            REG_OWNED_COUNT: cfg_in.owned_count = pwdata[OCOUNT_W-1:0];
            REG_GHOST_COUNT: cfg_in.ghost_count = pwdata[GCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_OWNED_BEGIN: prdata = CSR_DATA_W'(cfg_ff.owned_begin);
         REG_OWNED_COUNT: prdata = CSR_DATA_W'(cfg_ff.owned_count);
         REG_GHOST_COUNT: prdata = CSR_DATA_W'(cfg_ff.ghost_count);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/g2l_search_seq.sv]
// ----------------------------------------------------------------------------
// g2l_search_seq
// Sequencer for the owned range check and the lower-bound ghost search.
// ----------------------------------------------------------------------------
module g2l_search_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  g2l_pkg::cfg_type           cfg,
   g2l_req_if.sink                    req,
   g2l_rsp_if.source                  rsp,
   output g2l_pkg::ram_req_type       ram_req,
   input  logic [g2l_pkg::ROW_W-1:0]  rd_data
);
   import g2l_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_FINAL  = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [CNT_W-1:0]   lim_ff, lim_in;
   logic [INDEX_W-1:0] res_index_ff, res_index_in;
   logic               res_found_ff, res_found_in;
   logic               res_ghost_ff, res_ghost_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] out_index_ff, out_index_in;
   logic               out_found_ff, out_found_in;
   logic               out_ghost_ff, out_ghost_in;

   logic               accept;
   logic               owned;
   logic [CNT_W-1:0]   limit;
   logic               less;
   logic [CNT_W-1:0]   lo_step, hi_step, mid_step;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;

   // The upper bound uses 33 bits so that begin + count never wraps.
   assign owned = (row_ff >= cfg.owned_begin) &&
                  ({1'b0, row_ff} < ({1'b0, cfg.owned_begin} + 33'(cfg.owned_count)));

   assign limit = (32'(cfg.ghost_count) > 32'(GHOST_DEPTH)) ?
                  CNT_W'(GHOST_DEPTH) : CNT_W'(cfg.ghost_count);

   // One probe per cycle: the read data belongs to mid_ff.
   assign less     = rd_data < row_ff;
   assign lo_step  = less ? (mid_ff + 1'b1) : lo_ff;
   assign hi_step  = less ? hi_ff : mid_ff;
   assign mid_step = lo_step + ((hi_step - lo_step) >> 1);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      lim_in       = lim_ff;
      res_index_in = res_index_ff;
      res_found_in = res_found_ff;
      res_ghost_in = res_ghost_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_index_in = out_index_ff;
      out_found_in = out_found_ff;
      out_ghost_in = out_ghost_ff;
      ram_req      = '0;
      ram_req.wr_addr = IDX_W'(req.slot);
      ram_req.wr_data = req.row;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.mode == MODE_LOAD) begin
                  ram_req.wr_en = (32'(req.slot) < 32'(GHOST_DEPTH));
               end else begin
                  row_in   = req.row;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (owned) begin
               res_index_in = row_ff - cfg.owned_begin;
               res_found_in = 1'b1;
               res_ghost_in = 1'b0;
               state_in     = ST_RESULT;
            end else begin
               lo_in           = '0;
               hi_in           = limit;
               lim_in          = limit;
               mid_in          = limit >> 1;
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = IDX_W'(limit >> 1);
               // With an empty table mid is zero, so the read also serves the final check.
               state_in        = (limit != '0) ? ST_SEARCH : ST_FINAL;
            end
         end
         ST_SEARCH: begin
            lo_in         = lo_step;
            hi_in         = hi_step;
            ram_req.rd_en = 1'b1;
            if (lo_step < hi_step) begin
               mid_in          = mid_step;
               ram_req.rd_addr = IDX_W'(mid_step);
            end else begin
               ram_req.rd_addr = IDX_W'(lo_step);
               state_in        = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if ((lo_ff < lim_ff) && (rd_data == row_ff)) begin
               res_index_in = INDEX_W'(33'(cfg.owned_count) + 33'(lo_ff));
               res_found_in = 1'b1;
               res_ghost_in = 1'b1;
            end else begin
               res_index_in = '0;
               res_found_in = 1'b0;
               res_ghost_in = 1'b0;
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               out_index_in = res_index_ff;
               out_found_in = res_found_ff;
               out_ghost_in = res_ghost_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      lim_ff       <= lim_in;
      res_index_ff <= res_index_in;
      res_found_ff <= res_found_in;
      res_ghost_ff <= res_ghost_in;
      out_index_ff <= out_index_in;
      out_found_ff <= out_found_in;
      out_ghost_ff <= out_ghost_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.local_index = out_index_ff;
   assign rsp.found       = out_found_ff;
   assign rsp.is_ghost    = out_ghost_ff;

endmodule

[tb/global_to_local_row_map_test.sv]
// ----------------------------------------------------------------------------
// Global-to-local row map testbench
// Loads a sorted ghost table, then sends lookups and table loads under several
// owned-range and ghost-count settings. Each lookup is predicted when it is
// accepted and checked against the results in order. Both channels stall at
// random.
// ----------------------------------------------------------------------------
module global_to_local_row_map_test;
   timeunit 1ns;
   timeprecision 1ps;

   import g2l_pkg::*;

   localparam int SETTLE_CYCLES = 30;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int BUCKET_W      = ROW_W - SLOT_W;

   typedef struct packed {
      logic              mode;
      logic [ROW_W-1:0]  row;
      logic [SLOT_W-1:0] slot;
   } row_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0] local_index;
      logic               found;
      logic               is_ghost;
   } row_mapping_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   g2l_req_if req_if ();
   g2l_rsp_if rsp_if ();

   global_to_local_row_map dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   row_item_type     row_items[$];
   row_mapping_type  due_mappings[$];
   // The stimulus side keeps its own view of the table, since loads reach the
   // block later than they are queued.
   logic [ROW_W-1:0] plan_table[GHOST_DEPTH];
   logic [ROW_W-1:0] ghost_mem[GHOST_DEPTH];
   cfg_type          map_cfg = '0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               mismatch_count = 0;
   int               stall_cycles = 0;
   logic             req_fire = 1'b0;
   row_mapping_type  got_mapping;
   row_mapping_type  want_mapping;

   always #5 clock = ~clock;

   function automatic row_mapping_type map_global_row(logic [ROW_W-1:0] row);
      row_mapping_type m;
      logic [ROW_W:0] range_end;
      int unsigned    n;
      int unsigned    lo;
      int unsigned    hi;
      int unsigned    mid;
      m = '0;
      range_end = {1'b0, map_cfg.owned_begin} + (ROW_W + 1)'(map_cfg.owned_count);
      if ({1'b0, row} >= {1'b0, map_cfg.owned_begin} && {1'b0, row} < range_end) begin
         m.local_index = row - map_cfg.owned_begin;
         m.found = 1'b1;
         return m;
      end
      n = (map_cfg.ghost_count > GHOST_DEPTH) ? GHOST_DEPTH : map_cfg.ghost_count;
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (ghost_mem[mid] < row) lo = mid + 1;
         else hi = mid;
      end
      if (lo < n && ghost_mem[lo] == row) begin
         m.local_index = INDEX_W'(map_cfg.owned_count) + INDEX_W'(lo);
         m.found = 1'b1;
         m.is_ghost = 1'b1;
      end
      return m;
   endfunction

   function automatic logic [ROW_W-1:0] pick_row();
      int unsigned n;
      int unsigned k;
      logic [63:0] span;
      n = (map_cfg.ghost_count > GHOST_DEPTH) ? GHOST_DEPTH : map_cfg.ghost_count;
      span = 64'h1_0000_0000 - map_cfg.owned_begin;
      if (map_cfg.owned_count < span) span = map_cfg.owned_count;
      k = $urandom_range(99);
      if (span != 0 && k < 25) return map_cfg.owned_begin + ROW_W'({$urandom} % span);
      if (k < 32) begin
         case ($urandom_range(2))
            0:       return map_cfg.owned_begin - 1;
            1:       return map_cfg.owned_begin + ROW_W'(span);
            default: return map_cfg.owned_begin + ROW_W'(span) - 1;
         endcase
      end
      if (n != 0 && k < 67) return plan_table[$urandom_range(n - 1)];
      if (n != 0 && k < 77) begin
         if ($urandom_range(1)) return plan_table[$urandom_range(n - 1)] + 1;
         return plan_table[$urandom_range(n - 1)] - 1;
      end
      if (k < 87) return plan_table[$urandom_range(GHOST_DEPTH - 1)];
      return $urandom;
   endfunction

   task automatic queue_lookup(logic [ROW_W-1:0] row);
      row_item_type item;
      item = '{MODE_LOOKUP, row, SLOT_W'($urandom)};
      row_items = {row_items, item};
   endtask

   task automatic queue_load(int slot, logic [ROW_W-1:0] row);
      row_item_type item;
      item = '{MODE_LOAD, row, SLOT_W'(slot)};
      row_items = {row_items, item};
      plan_table[slot] = row;
   endtask

   // Rewrites a slot with a value between its neighbors, so the table stays
   // sorted; equal neighbors come up now and then.
   task automatic queue_sorted_load(int slot);
      logic [ROW_W-1:0] lowv;
      logic [ROW_W-1:0] highv;
      logic [63:0]      span;
      lowv = (slot == 0) ? '0 : plan_table[slot - 1];
      highv = (slot == GHOST_DEPTH - 1) ? '1 : plan_table[slot + 1];
      span = 64'(highv) - 64'(lowv) + 1;
      if ($urandom_range(3) == 0) queue_load(slot, lowv);
      else queue_load(slot, lowv + ROW_W'({$urandom} % span));
   endtask

   task automatic queue_random(int count, int scramble_pct);
      int slot;
      repeat (count) begin
         if ($urandom_range(99) < 12) begin
            slot = $urandom_range(GHOST_DEPTH - 1);
            if ($urandom_range(99) < scramble_pct) queue_load(slot, $urandom);
            else queue_sorted_load(slot);
         end else begin
            queue_lookup(pick_row());
         end
      end
   endtask

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (idx)
         REG_OWNED_BEGIN: map_cfg.owned_begin = value;
         REG_OWNED_COUNT: map_cfg.owned_count = value[OCOUNT_W-1:0];
         REG_GHOST_COUNT: map_cfg.ghost_count = value[GCOUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Loads give no result, so a last load may still be in the block when the
   // last lookup result arrives; the settle time covers it.
   task automatic wait_idle();
      do @(posedge clock);
      while (row_items.size() != 0 || req_if.valid || due_mappings.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic report_mismatch(string what, row_mapping_type want,
                                  row_mapping_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] %s: expected index %0d found %0b ghost %0b, %s %0d %s %0b %s %0b",
                  $time, what, want.local_index, want.found, want.is_ghost,
                  "got index", got.local_index, "found", got.found, "ghost",
                  got.is_ghost);
      end
   endtask

   // Driver and receiver side: inputs change on the falling edge only.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (!req_if.valid || req_fire) begin
            if (row_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.valid <= 1'b1;
               req_if.mode <= row_items[0].mode;
               req_if.row <= row_items[0].row;
               req_if.slot <= row_items[0].slot;
               row_items.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      req_fire <= req_if.valid && req_if.ready;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            if (req_if.mode == MODE_LOAD) ghost_mem[req_if.slot] = req_if.row;
            else due_mappings = {due_mappings, map_global_row(req_if.row)};
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got_mapping = {rsp_if.local_index, rsp_if.found, rsp_if.is_ghost};
            if (due_mappings.size() == 0) begin
               report_mismatch("result with no lookup outstanding", '0, got_mapping);
            end else begin
               want_mapping = due_mappings.pop_front();
               if (got_mapping.local_index !== want_mapping.local_index ||
                   got_mapping.found !== want_mapping.found ||
                   got_mapping.is_ghost !== want_mapping.is_ghost) begin
                  report_mismatch("lookup result differs", want_mapping, got_mapping);
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (psel && penable)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
               $display("FAILURE");
               $finish;
            end
         end
      end
   end

   initial begin
      logic [ROW_W-1:0] ob;
      logic [ROW_W-1:0] oc;
      req_if.valid = 1'b0;
      req_if.mode = MODE_LOOKUP;
      req_if.row = '0;
      req_if.slot = '0;
      rsp_if.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      send_idle_pct = 26;
      recv_idle_pct = 83;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Ghost count is still zero, so these lookups never probe the table.
      queue_lookup('0);
      queue_lookup('1);
      queue_lookup($urandom);
      // Slot i holds a value in the i-th slice of the row space: sorted.
      for (int i = 0; i < GHOST_DEPTH; i++) queue_load(i, {SLOT_W'(i), BUCKET_W'($urandom)});
      queue_load(0, '0);
      queue_load(GHOST_DEPTH - 1, '1);
      wait_idle();

      // The owned range covers part of the table, so owned rows shadow ghosts.
      ob = plan_table[100];
      oc = plan_table[200] - ob;
      write_reg(REG_OWNED_BEGIN, ob);
      write_reg(REG_OWNED_COUNT, oc);
      write_reg(REG_GHOST_COUNT, GHOST_DEPTH);
      queue_lookup(ob);
      queue_lookup(ob + oc - 1);
      queue_lookup(ob + oc);
      queue_lookup(ob - 1);
      queue_lookup(plan_table[150]);
      queue_lookup(plan_table[0]);
      queue_lookup(plan_table[GHOST_DEPTH - 1]);
      queue_lookup(plan_table[99]);
      queue_lookup(plan_table[512]);
      queue_lookup(plan_table[512] + 1);
      queue_lookup(32'hFFFF_FFFE);
      queue_sorted_load(700);
      queue_lookup(plan_table[700]);
      queue_load(0, '0);
      queue_lookup('0);
      queue_random(60, 0);
      wait_idle();

      send_idle_pct = 83;
      recv_idle_pct = 26;
      // The owned range runs past the top of the row space; the ghost count
      // exceeds the table depth.
      write_reg(REG_OWNED_BEGIN, 32'hFFFF_FF00);
      write_reg(REG_OWNED_COUNT, 32'h7FFF_FFFF);
      write_reg(REG_GHOST_COUNT, 32'h0000_07FF);
      queue_random(60, 0);
      wait_idle();

      write_reg(REG_OWNED_BEGIN, $urandom);
      write_reg(REG_OWNED_COUNT, '0);
      write_reg(REG_GHOST_COUNT, 1);
      queue_random(30, 0);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(REG_OWNED_BEGIN, '0);
      write_reg(REG_OWNED_COUNT, 32'h7FFF_FFFF);
      write_reg(REG_GHOST_COUNT, $urandom_range(GHOST_DEPTH, 1));
      queue_random(60, 0);
      wait_idle();

      // Random loads leave the table unsorted here.
      write_reg(REG_OWNED_BEGIN, $urandom);
      write_reg(REG_OWNED_COUNT, $urandom_range(1 << 20));
      write_reg(REG_GHOST_COUNT, GHOST_DEPTH);
      queue_random(60, 60);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
